>>> rtl/sae_pkg.sv
// Package for the source azimuth/elevation block: constants, types, arctangent table.
package sae_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int ATAN_LEN            = 24;

  localparam int W_ACC = 34;

  localparam logic signed [W_ACC-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [W_ACC-1:0] DEG_90       = 34'sd1509949440;
  localparam logic signed [W_ACC-1:0] DEG_180      = 34'sd3019898880;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL    = 9'b000000010,
    ST_NORM   = 9'b000000100,
    ST_CSTART = 9'b000001000,
    ST_CITER  = 9'b000010000,
    ST_CFIN   = 9'b000100000,
    ST_GAIN   = 9'b001000000,
    ST_GLOAD  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic [31:0] atan_q24(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/source_azimuth_elevation.sv
// Source azimuth/elevation: affine transform, normalize, two CORDIC vectoring passes.
// A load word is stored as it is accepted; a position goes through the dot products, normalize,
//   the azimuth CORDIC pass, the gain step and the elevation pass (a zero direction skips CORDIC).
// Throughput: one position at a time; set by the single shared multiplier and
//   the single CORDIC rotator, reused for the dot products and gain step and for both passes.
// Reset: async active low; transform store cleared to zero, no result pending.
module source_azimuth_elevation
  import sae_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [3:0]         matrix_index_i,
  input  logic signed [31:0] matrix_value_i,
  input  logic signed [31:0] source_x_i,
  input  logic signed [31:0] source_y_i,
  input  logic signed [31:0] source_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        azimuth_angle_o,
  output logic signed [14:0] elevation_angle_o
);

  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic signed [W_ACC-1:0] RND_HALF = W_ACC'(64'sd1 <<< (23 - ANGLE_FRAC_BITS));
  localparam logic signed [W_ACC-1:0] FULL = W_ACC'(64'sd360 <<< ANGLE_FRAC_BITS);
  localparam logic signed [W_ACC-1:0] LIM  = W_ACC'(64'sd90 <<< ANGLE_FRAC_BITS);
  localparam logic [4:0] LAST_IT = 5'(STEPS_EFF - 1);

  state_e state_q, state_d;

  logic [31:0] store_q [12];

  logic signed [31:0] px_q, py_q, pz_q;
  logic [1:0]  row_q;
  logic [1:0]  col_q;
  logic signed [63:0] acc64_q, prod_q;
  logic signed [63:0] dx_q, dy_q, dz_q;
  logic [63:0] mor_q;
  logic        zdepth_q;

  logic              pass_el_q;
  logic signed [W_ACC-1:0] cb_q, ca_q, cacc_q, hyp_q;
  logic [4:0]        it_q;
  logic              b0neg_q, b0zero_q, a0pos_q, a0zero_q;
  logic [15:0]       az_tmp_q, az_q;
  logic [14:0]       el_tmp_q, el_q;
  logic              out_valid_q;

  logic signed [W_ACC-1:0] mul_a, mul_b;
  logic signed [2*W_ACC-1:0] mul_p;
  logic signed [31:0] word, coord;
  logic signed [63:0] row_sum, trans;
  logic [63:0] row_mag;

  logic signed [W_ACC-1:0] src_b, src_a, sh_a, sh_b, ang, rnd, azv, elv;
  logic signed [W_ACC-1:0] atan_v;

  logic in_acc, out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_OUT) & (~out_valid_q | out_ready_i);

  assign word = store_q[{row_q, col_q}];
  always_comb begin
    case (col_q)
      2'd0:    coord = px_q;
      2'd1:    coord = py_q;
      default: coord = pz_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_GAIN) begin
      mul_a = cb_q;
      mul_b = INV_GAIN_Q30;
    end else begin
      mul_a = W_ACC'(word);
      mul_b = W_ACC'(coord);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign trans   = {{18{word[31]}}, word, 14'b0};
  assign row_sum = acc64_q + (prod_q >>> 2) + trans;
  assign row_mag = row_sum[63] ? 64'(-row_sum) : row_sum;

  // CORDIC source vector for the pass
  assign src_b  = pass_el_q ? hyp_q : dz_q[W_ACC-1:0];
  assign src_a  = pass_el_q ? dy_q[W_ACC-1:0] : dx_q[W_ACC-1:0];
  assign sh_a   = ca_q >>> it_q;
  assign sh_b   = cb_q >>> it_q;
  assign atan_v = W_ACC'(atan_q24(it_q));

  always_comb begin
    if (a0zero_q)      ang = b0neg_q ? DEG_180 : '0;
    else if (b0zero_q) ang = a0pos_q ? DEG_90 : -DEG_90;
    else               ang = cacc_q;
    rnd = (ang + RND_HALF) >>> (24 - ANGLE_FRAC_BITS);
    azv = zdepth_q ? '0 : rnd;
    if (azv < 0)    azv = azv + FULL;
    if (azv < 0)    azv = '0;
    if (azv > FULL) azv = FULL;
    elv = rnd;
    if (elv > LIM)  elv = LIM;
    if (elv < -LIM) elv = -LIM;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && command_i) state_d = ST_MUL;
      ST_MUL:    if (row_q == 2'd2 && col_q == 2'd3) state_d = ST_NORM;
      ST_NORM: begin
        if (mor_q == '0)                      state_d = ST_OUT;
        else if (mor_q[63:29] == '0 && mor_q[28]) state_d = ST_CSTART;
      end
      ST_CSTART: state_d = ST_CITER;
      ST_CITER:  if (it_q == LAST_IT) state_d = ST_CFIN;
      ST_CFIN:   state_d = pass_el_q ? ST_OUT : ST_GAIN;
      ST_GAIN:   state_d = ST_GLOAD;
      ST_GLOAD:  state_d = ST_CSTART;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 12; i++) store_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_acc && !command_i && matrix_index_i < 4'd12)
        store_q[matrix_index_i] <= matrix_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q      <= source_x_i;
        py_q      <= source_y_i;
        pz_q      <= source_z_i;
        row_q     <= '0;
        col_q     <= '0;
        acc64_q   <= '0;
        prod_q    <= '0;
        mor_q     <= '0;
        pass_el_q <= 1'b0;
        az_tmp_q  <= '0;
        el_tmp_q  <= '0;
      end
      ST_MUL: begin
        if (col_q == 2'd3) begin
          acc64_q <= '0;
          prod_q  <= '0;
          mor_q   <= mor_q | row_mag;
          case (row_q)
            2'd0:    dx_q <= row_sum;
            2'd1:    dy_q <= row_sum;
            default: begin
              dz_q     <= row_sum;
              zdepth_q <= (row_sum == '0);
            end
          endcase
          row_q <= row_q + 2'd1;
        end else begin
          prod_q  <= mul_p[63:0];
          acc64_q <= acc64_q + (prod_q >>> 2);
        end
        col_q <= col_q + 2'd1;
      end
      ST_NORM: begin
        if (mor_q[63:33] != '0) begin
          mor_q <= mor_q >> 4;
          dx_q  <= dx_q >>> 4;
          dy_q  <= dy_q >>> 4;
          dz_q  <= dz_q >>> 4;
        end else if (mor_q[63:29] != '0) begin
          mor_q <= mor_q >> 1;
          dx_q  <= dx_q >>> 1;
          dy_q  <= dy_q >>> 1;
          dz_q  <= dz_q >>> 1;
        end else if (mor_q != '0 && mor_q[28:24] == '0) begin
          mor_q <= mor_q << 4;
          dx_q  <= dx_q <<< 4;
          dy_q  <= dy_q <<< 4;
          dz_q  <= dz_q <<< 4;
        end else if (mor_q != '0 && !mor_q[28]) begin
          mor_q <= mor_q << 1;
          dx_q  <= dx_q <<< 1;
          dy_q  <= dy_q <<< 1;
          dz_q  <= dz_q <<< 1;
        end
      end
      ST_CSTART: begin
        b0neg_q  <= src_b < 0;
        b0zero_q <= src_b == '0;
        a0pos_q  <= src_a > 0;
        a0zero_q <= src_a == '0;
        it_q     <= '0;
        if (src_b < 0) begin
          if (src_a >= 0) begin
            cb_q   <= src_a;
            ca_q   <= -src_b;
            cacc_q <= DEG_90;
          end else begin
            cb_q   <= -src_a;
            ca_q   <= src_b;
            cacc_q <= -DEG_90;
          end
        end else begin
          cb_q   <= src_b;
          ca_q   <= src_a;
          cacc_q <= '0;
        end
      end
      ST_CITER: begin
        if (ca_q >= 0) begin
          cb_q   <= cb_q + sh_a;
          ca_q   <= ca_q - sh_b;
          cacc_q <= cacc_q + atan_v;
        end else begin
          cb_q   <= cb_q - sh_a;
          ca_q   <= ca_q + sh_b;
          cacc_q <= cacc_q - atan_v;
        end
        it_q <= it_q + 5'd1;
      end
      ST_CFIN: begin
        if (pass_el_q) el_tmp_q <= elv[14:0];
        else           az_tmp_q <= azv[15:0];
      end
      ST_GAIN:  prod_q <= mul_p[63:0];
      ST_GLOAD: begin
        hyp_q     <= W_ACC'(prod_q >>> 30);
        pass_el_q <= 1'b1;
      end
      ST_OUT: begin
        if (out_load) begin
          az_q <= az_tmp_q;
          el_q <= el_tmp_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign azimuth_angle_o   = az_q;
  assign elevation_angle_o = el_q;

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CITER) |-> (it_q <= LAST_IT))
    else $error("cordic step count overran");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CSTART && !pass_el_q) |->
      (dx_q <= 64'sd536870912 && dx_q >= -64'sd536870912 &&
       dz_q <= 64'sd536870912 && dz_q >= -64'sd536870912))
    else $error("normalized vector out of range");

  a_hyp_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CSTART && pass_el_q) |-> (hyp_q >= 0))
    else $error("negative cordic magnitude");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i) |=> !in_ready_o)
    else $error("ready while converting");

endmodule

>>> tb/source_azimuth_elevation_test.sv
// Testbench for source_azimuth_elevation: predicts each angle pair and compares in order.
`timescale 1ns / 1ps

module source_azimuth_elevation_test;
  import sae_pkg::*;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam longint DEG90_Q24 = 64'sd1509949440;
  localparam longint DEG180_Q24 = 64'sd3019898880;
  localparam longint INV_GAIN = 64'sd652032874;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = CMD_LOAD;
  logic [3:0]         matrix_index_i = '0;
  logic signed [31:0] matrix_value_i = '0;
  logic signed [31:0] source_x_i = '0;
  logic signed [31:0] source_y_i = '0;
  logic signed [31:0] source_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        azimuth_angle_o;
  logic signed [14:0] elevation_angle_o;

  source_azimuth_elevation u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  longint atan_tab[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523,
    7509720, 3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115};

  logic signed [31:0] transform_words[12];
  logic [15:0]        az_expected[$];
  logic [14:0]        el_expected[$];
  int                 errors = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  logic               hold_off = 1'b0;
  logic               word_taken = 1'b0;

  function automatic void cordic_vector(input longint b0, input longint a0,
                                        output longint ang, output longint len);
    longint b, a, acc, nb, na;
    b = b0; a = a0; acc = 0;
    if (b < 0) begin
      if (a >= 0) begin
        nb = a; na = -b; acc = DEG90_Q24;
      end else begin
        nb = -a; na = b; acc = -DEG90_Q24;
      end
      b = nb; a = na;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        nb = b + (a >>> i); na = a - (b >>> i); acc += atan_tab[i];
      end else begin
        nb = b - (a >>> i); na = a + (b >>> i); acc -= atan_tab[i];
      end
      b = nb; a = na;
    end
    len = (b * INV_GAIN) >>> 30;
    if (a0 == 0) acc = (b0 >= 0) ? 0 : DEG180_Q24;
    else if (b0 == 0) acc = (a0 > 0) ? DEG90_Q24 : -DEG90_Q24;
    ang = acc;
  endfunction

  function automatic longint to_units(input longint acc);
    return (acc + (64'sd1 <<< (23 - FRAC))) >>> (24 - FRAC);
  endfunction

  function automatic longint row_direction(input int r, input longint px, input longint py,
                                           input longint pz);
    longint m0, m1, m2, t;
    m0 = transform_words[r*4];
    m1 = transform_words[r*4+1];
    m2 = transform_words[r*4+2];
    t = transform_words[r*4+3];
    return ((m0 * px) >>> 2) + ((m1 * py) >>> 2) + ((m2 * pz) >>> 2) + t * 64'sd16384;
  endfunction

  task automatic predict_direction(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [31:0] z);
    longint dx, dy, dz, m, az, el, ang, hyp;
    int len, s;
    bit zero_depth;
    dx = row_direction(0, x, y, z);
    dy = row_direction(1, x, y, z);
    dz = row_direction(2, x, y, z);
    zero_depth = (dz == 0);
    m = dx < 0 ? -dx : dx;
    if ((dy < 0 ? -dy : dy) > m) m = dy < 0 ? -dy : dy;
    if ((dz < 0 ? -dz : dz) > m) m = dz < 0 ? -dz : dz;
    if (m == 0) begin
      az = 0; el = 0;
    end else begin
      len = 0;
      while (len < 64 && (m >> len) != 0) len++;
      s = len - 29;
      if (s > 0) begin
        dx = dx >>> s; dy = dy >>> s; dz = dz >>> s;
      end else if (s < 0) begin
        dx = dx <<< -s; dy = dy <<< -s; dz = dz <<< -s;
      end
      cordic_vector(dz, dx, ang, hyp);
      az = zero_depth ? 0 : to_units(ang);
      if (az < 0) az += 360 << FRAC;
      if (az < 0) az = 0;
      if (az > (360 << FRAC)) az = 360 << FRAC;
      cordic_vector(hyp, dy, ang, hyp);
      el = to_units(ang);
      if (el > (90 << FRAC)) el = 90 << FRAC;
      if (el < -(90 << FRAC)) el = -(90 << FRAC);
    end
    az_expected.push_back(az[15:0]);
    el_expected.push_back(el[14:0]);
  endtask

  always @(posedge clk_i) begin
    word_taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (az_expected.size() == 0) begin
        $display("%0t: unexpected result az=%0d el=%0d", $time, azimuth_angle_o,
                 elevation_angle_o);
        errors++;
      end else begin
        if (azimuth_angle_o !== az_expected[0] || elevation_angle_o !== el_expected[0]) begin
          $display("%0t: mismatch expected az=%0d el=%0d actual az=%0d el=%0d", $time,
                   az_expected[0], $signed(el_expected[0]), azimuth_angle_o,
                   elevation_angle_o);
          errors++;
        end
        void'(az_expected.pop_front());
        void'(el_expected.pop_front());
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= !hold_off && ($urandom_range(99) >= rx_idle_pct);

  task automatic send_word(input logic cmd, input logic [3:0] idx,
                           input logic signed [31:0] val, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    matrix_index_i <= idx;
    matrix_value_i <= val;
    source_x_i <= x;
    source_y_i <= y;
    source_z_i <= z;
    do @(negedge clk_i); while (!word_taken);
    if (cmd == CMD_LOAD) begin
      if (idx < 12) transform_words[idx] = val;
    end else begin
      predict_direction(x, y, z);
    end
  endtask

  task automatic load_word(input logic [3:0] idx, input logic signed [31:0] val);
    send_word(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic convert(input logic signed [31:0] x, input logic signed [31:0] y,
                         input logic signed [31:0] z);
    send_word(CMD_CONVERT, 4'($urandom), $urandom, x, y, z);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (az_expected.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sd0;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(131072)) - 32'sd65536;
      3: return $signed($urandom_range(511)) - 32'sd256;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    convert(32'sd65536, 32'sd65536, 32'sd65536);    // zero store: zero direction
    load_word(4'd0, 32'sd65536);
    load_word(4'd5, 32'sd65536);
    load_word(4'd10, 32'sd65536);
    load_word(4'd12, 32'sd65536);                    // ignored index
    load_word(4'd15, 32'sh7fffffff);
    convert(32'sd65536, 32'sd0, 32'sd0);             // zero depth
    convert(32'sd0, 32'sd0, -32'sd65536);            // behind
    convert(32'sd0, 32'sd65536, 32'sd0);
    convert(32'sd0, -32'sd65536, 32'sd0);
    convert(-32'sd65536, 32'sd0, 32'sd65536);
    convert(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    convert(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    convert(32'sd1, -32'sd1, -32'sd1);
    convert(32'sd0, 32'sd0, 32'sd0);
    load_word(4'd3, 32'sh7fffffff);
    load_word(4'd7, 32'sh80000000);
    load_word(4'd11, 32'sd12345);
    convert(32'sh80000000, 32'sh80000000, 32'sh80000000);
    convert(32'sd100, 32'sd200, -32'sd300);
    load_word(4'd1, 32'sh80000000);
    load_word(4'd8, 32'sh7fffffff);
    convert(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    drain();
  endtask

  task automatic test_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(19))
        0, 1: begin
          for (int i = 0; i < 12; i++) load_word(i[3:0], rand_coord());
          sent += 12;
        end
        2: begin
          load_word(4'($urandom), $urandom);
          sent++;
        end
        default: begin
          convert(rand_coord(), rand_coord(), rand_coord());
          sent++;
        end
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) convert(rand_coord(), rand_coord(), rand_coord());
    join
    drain();
  endtask

  initial begin
    foreach (transform_words[i]) transform_words[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    tx_idle_pct = 28; rx_idle_pct = 47;
    test_random(580);
    test_backpressure();
    tx_idle_pct = 47; rx_idle_pct = 28;
    test_random(580);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random(580);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> source_azimuth_elevation.f
rtl/sae_pkg.sv
rtl/source_azimuth_elevation.sv
tb/source_azimuth_elevation_test.sv
